### rtl/assert_macros.svh
// Assertion helpers shared by the decoder RTL.
// Both macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### rtl/ps2d_pkg.sv
// ============================================================================
// ps2d_pkg
// Shared types and codes for the PS/2 keyboard and mouse byte decoder.
// ============================================================================
package ps2d_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_KEY      = 2'd0,
        KIND_MOUSE    = 2'd1,
        KIND_LED      = 2'd2,
        KIND_MOUSE_EN = 2'd3
    } kind_t;

    // Keyboard set-2 codes
    localparam logic [7:0] KEY_OVERRUN = 8'h00;
    localparam logic [7:0] KEY_E0      = 8'hE0;
    localparam logic [7:0] KEY_E1      = 8'hE1;
    localparam logic [7:0] KEY_F0      = 8'hF0;
    localparam logic [7:0] KEY_ALT     = 8'h11;
    localparam logic [7:0] KEY_LSHIFT  = 8'h12;
    localparam logic [7:0] KEY_RSHIFT  = 8'h59;
    localparam logic [7:0] KEY_CTRL    = 8'h14;
    localparam logic [7:0] KEY_LWIN    = 8'h1F;
    localparam logic [7:0] KEY_RWIN    = 8'h27;
    localparam logic [7:0] KEY_NUMLOCK = 8'h77;
    localparam logic [7:0] KEY_SYSCTRL = 8'h7E;

    // Mouse codes
    localparam logic [7:0] MOUSE_ACK  = 8'hAA;
    localparam logic [7:0] MOUSE_ID   = 8'h00;
    localparam int         MOUSE_SYNC = 3;

    // Prefix flag bits (same layout as event_flags)
    localparam logic [2:0] PF_REL = 3'b001;
    localparam logic [2:0] PF_E0  = 3'b010;
    localparam logic [2:0] PF_E1  = 3'b100;

    // Modifier mask bits
    localparam logic [8:0] MASK_NUM    = 9'h001;
    localparam logic [8:0] MASK_LSHIFT = 9'h002;
    localparam logic [8:0] MASK_RSHIFT = 9'h004;
    localparam logic [8:0] MASK_LCTRL  = 9'h008;
    localparam logic [8:0] MASK_RCTRL  = 9'h010;
    localparam logic [8:0] MASK_LALT   = 9'h020;
    localparam logic [8:0] MASK_RALT   = 9'h040;
    localparam logic [8:0] MASK_LWIN   = 9'h080;
    localparam logic [8:0] MASK_RWIN   = 9'h100;

    localparam logic [2:0] LED_NUM_ON = 3'd2;

    // One result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key_code;
        logic [2:0]  event_flags;
        logic [8:0]  modifiers;
        logic [23:0] mouse_packet;
        logic [2:0]  led_bits;
        logic        last;
    } res_t;

    // Up to two results from one decoded byte
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } dec_t;

endpackage

### rtl/ps2d_ifs.sv
// ============================================================================
// ps2d_ifs
// Valid/ready channels for decoder requests and results.
// ============================================================================
interface ps2d_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       from_aux;

    modport source (output valid, output data_byte, output from_aux, input ready);
    modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface ps2d_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  key_code;
    logic [2:0]  event_flags;
    logic [8:0]  modifiers;
    logic [23:0] mouse_packet;
    logic [2:0]  led_bits;
    logic        last;

    modport source (
        output valid, output kind, output key_code, output event_flags,
        output modifiers, output mouse_packet, output led_bits, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input key_code, input event_flags,
        input modifiers, input mouse_packet, input led_bits, input last,
        output ready
    );
endinterface

### rtl/ps2d_kbd.sv
// ============================================================================
// ps2d_kbd
// Scancode set 2 decoder: prefix flags, modifier mask, num lock LED request.
// ============================================================================
module ps2d_kbd (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    key,
    output ps2d_pkg::dec_t dec
);
    import ps2d_pkg::*;

    logic [2:0] prefix_reg, prefix_next;
    logic [8:0] mod_reg, mod_next;
    logic [8:0] add;
    logic [8:0] mod_tog;
    logic [8:0] mod_evt;
    logic       e0, e1, rel;
    logic       pass, led_hit, key_hit, swallow;
    res_t       led_res, key_res;

    assign e0  = prefix_reg[1];
    assign e1  = prefix_reg[2];
    assign rel = prefix_reg[0];

    // Decode the byte against the current prefix state
    always_comb
    begin
        prefix_next = prefix_reg;
        mod_next    = mod_reg;
        add         = '0;
        pass        = 1'b1;
        led_hit     = 1'b0;
        unique case (key) inside
            KEY_OVERRUN:
            begin
                prefix_next = '0;
                mod_next    = mod_reg & MASK_NUM;
                pass        = 1'b0;
            end
            KEY_E0:
            begin
                prefix_next = prefix_reg | PF_E0;
                pass        = 1'b0;
            end
            KEY_E1:
            begin
                prefix_next = prefix_reg | PF_E1;
                pass        = 1'b0;
            end
            KEY_F0:
            begin
                prefix_next = prefix_reg | PF_REL;
                pass        = 1'b0;
            end
            KEY_ALT:
            begin
                add = e0 ? MASK_RALT : MASK_LALT;
            end
            KEY_LSHIFT, KEY_RSHIFT:
            begin
                if (e0)
                begin
                    // fake shift around extended keys: drop E0 and release
                    prefix_next = prefix_reg & PF_E1;
                    pass        = 1'b0;
                end
                else
                begin
                    add = (key == KEY_LSHIFT) ? MASK_LSHIFT : MASK_RSHIFT;
                end
            end
            KEY_CTRL:
            begin
                add = e0 ? MASK_RCTRL : MASK_LCTRL;
            end
            KEY_LWIN:
            begin
                add = e0 ? MASK_LWIN : '0;
            end
            KEY_RWIN:
            begin
                add = e0 ? MASK_RWIN : '0;
            end
            KEY_NUMLOCK:
            begin
                led_hit = !e1 && !rel;
            end
            default:
            begin
                add = '0;
            end
        endcase

        mod_tog = led_hit ? (mod_reg ^ MASK_NUM) : mod_reg;

        // sysctrl and pause sequences are swallowed with prefixes kept
        swallow = (e0 && !rel && key == KEY_SYSCTRL) ||
                  (e1 && (key == KEY_CTRL || (key == KEY_NUMLOCK && !rel)));
        key_hit = pass && !swallow;
        mod_evt = rel ? (mod_tog & ~add) : (mod_tog | add);

        if (pass)
        begin
            mod_next = key_hit ? mod_evt : mod_tog;
            if (key_hit)
            begin
                prefix_next = '0;
            end
        end
    end

    // Build the result items
    always_comb
    begin
        led_res          = '0;
        led_res.kind     = KIND_LED;
        led_res.led_bits = mod_tog[0] ? LED_NUM_ON : 3'd0;
        led_res.last     = !key_hit;

        key_res             = '0;
        key_res.kind        = KIND_KEY;
        key_res.key_code    = key;
        key_res.event_flags = prefix_reg;
        key_res.modifiers   = mod_evt;
        key_res.last        = 1'b1;

        dec = '0;
        dec.count = {1'b0, led_hit} + {1'b0, key_hit};
        if (led_hit)
        begin
            dec.r0 = led_res;
            dec.r1 = key_res;
        end
        else
        begin
            dec.r0 = key_res;
        end
    end

    // Hold state until a keyboard byte is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            mod_reg    <= MASK_NUM;
        end
        else if (fire)
        begin
            prefix_reg <= prefix_next;
            mod_reg    <= mod_next;
        end
    end

endmodule

### rtl/ps2d_mouse.sv
// ============================================================================
// ps2d_mouse
// Mouse bring-up tracking and 3-byte packet assembly with sync check.
// ============================================================================
module ps2d_mouse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic [7:0]    data,
    output ps2d_pkg::dec_t dec
);
    import ps2d_pkg::*;

    typedef enum logic [4:0] {
        PH_ACK  = 5'b00001,
        PH_ID   = 5'b00010,
        PH_PKT0 = 5'b00100,
        PH_PKT1 = 5'b01000,
        PH_PKT2 = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_reg, bytes_next;

    // Advance the bring-up and packet phases
    always_comb
    begin
        phase_next = phase_reg;
        bytes_next = bytes_reg;
        dec        = '0;
        unique case (phase_reg)
            PH_ACK:
            begin
                if (data == MOUSE_ACK)
                begin
                    phase_next = PH_ID;
                end
            end
            PH_ID:
            begin
                if (data == MOUSE_ID)
                begin
                    phase_next      = PH_PKT0;
                    bytes_next      = '0;
                    dec.count       = 2'd1;
                    dec.r0.kind     = KIND_MOUSE_EN;
                    dec.r0.last     = 1'b1;
                end
            end
            PH_PKT1:
            begin
                bytes_next = {data, bytes_reg[7:0]};
                phase_next = PH_PKT2;
            end
            PH_PKT2:
            begin
                phase_next          = PH_PKT0;
                bytes_next          = '0;
                dec.count           = 2'd1;
                dec.r0.kind         = KIND_MOUSE;
                dec.r0.mouse_packet = {data, bytes_reg};
                dec.r0.last         = 1'b1;
            end
            default:
            begin
                // first packet byte: drop it when the sync bit is clear
                if (data[MOUSE_SYNC])
                begin
                    bytes_next = {8'h00, data};
                    phase_next = PH_PKT1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACK;
            bytes_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule

### rtl/ps2d_resq.sv
// ============================================================================
// ps2d_resq
// Four-entry result queue; takes up to two results per cycle, gives one.
// ============================================================================
`include "assert_macros.svh"

module ps2d_resq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ps2d_pkg::dec_t push_dec,
    output logic           room,
    output logic           head_valid,
    input  logic           head_ready,
    output ps2d_pkg::res_t head
);
    import ps2d_pkg::*;

    res_t       q_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] push_n;
    logic       pop;

    assign push_n     = push ? push_dec.count : 2'd0;
    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != 3'd0);
    assign head       = q_reg[rd_ptr_reg];
    // two free slots are needed for the worst-case byte
    assign room       = (count_reg <= 3'd2);

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push_dec.r0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= push_dec.r1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {1'b0, push_n} - {2'b00, pop};
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, (push_n != 2'd0) && (count_reg > 3'd2), "result queue overflow")
    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > 3'd4, "result queue count out of range")
    `ASSERT_CLK(a_pair_last, clk, rst_n, (push_n == 2'd2) |-> (!push_dec.r0.last && push_dec.r1.last), "last flag misplaced in result pair")

endmodule

### rtl/ps2_scancode_and_mouse_decoder.sv
// ============================================================================
// ps2_scancode_and_mouse_decoder
// PS/2 keyboard (set 2) and mouse byte decoder with a result queue.
// ============================================================================
// Path: a taken byte waits in the input register, is decoded and pushed into the result queue.
// Throughput: one byte per cycle while the result side keeps up; a byte that
// gives two results (num lock) hands them to the result port one after the other.
// The input register stalls when the result queue has fewer than two free slots.
// Reset: asynchronous; prefixes clear, num lock on, mouse awaits reset ack.
`include "assert_macros.svh"

module ps2_scancode_and_mouse_decoder (
    input  logic       clk,
    input  logic       rst_n,
    ps2d_req_if.sink   req,
    ps2d_rsp_if.source rsp
);
    import ps2d_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_aux_reg;
    logic       room;
    logic       fire;
    dec_t       kbd_dec, mouse_dec, dec;
    res_t       head;

    // Decode the held byte once the queue can take both results
    assign fire      = s1_valid_reg && room;
    assign req.ready = !s1_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_byte_reg <= req.data_byte;
            s1_aux_reg  <= req.from_aux;
        end
    end

    ps2d_kbd u_kbd (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire && !s1_aux_reg),
        .key   (s1_byte_reg),
        .dec   (kbd_dec)
    );

    ps2d_mouse u_mouse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire && s1_aux_reg),
        .data  (s1_byte_reg),
        .dec   (mouse_dec)
    );

    assign dec = s1_aux_reg ? mouse_dec : kbd_dec;

    ps2d_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_dec   (dec),
        .room       (room),
        .head_valid (rsp.valid),
        .head_ready (rsp.ready),
        .head       (head)
    );

    // Drive the result channel
    assign rsp.kind         = head.kind;
    assign rsp.key_code     = head.key_code;
    assign rsp.event_flags  = head.event_flags;
    assign rsp.modifiers    = head.modifiers;
    assign rsp.mouse_packet = head.mouse_packet;
    assign rsp.led_bits     = head.led_bits;
    assign rsp.last         = head.last;

    `ASSERT_CLK(a_hold_stalled, clk, rst_n, (s1_valid_reg && !room) |=> (s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_aux_reg)), "stalled byte lost")
    `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !s1_valid_reg |-> req.ready, "input blocked while empty")
    `ASSERT_NEVER(a_led_only_kbd, clk, rst_n, fire && s1_aux_reg && (dec.count == 2'd2), "mouse byte gave two results")

endmodule
